### hdl/pcpfl_pkg.sv
package pcpfl_pkg;

	// Field widths fixed by the interface
	localparam int unsigned ADDR_W      = 34;
	localparam int unsigned CPU_FIELD_W = 3;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned CFG_IDX_W   = 1;

	// Default sizing
	localparam int unsigned CPU_COUNT_DEF  = 8;
	localparam int unsigned NUM_PAGES_DEF  = 32768;
	localparam int unsigned PAGE_BYTES_DEF = 4096;

	// Register reset values
	localparam logic [ADDR_W-1:0] REGION_START_RST = 34'h0_8000_0000;
	localparam logic [ADDR_W-1:0] REGION_END_RST   = 34'h0_8800_0000;

	// Operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

	// Write controls from the sequencer to the list store
	typedef struct packed {
		logic head_we;
		logic head_valid;
		logic link_we;
	} st_ctl_t;

	// Reduce a CPU number modulo the CPU count by repeated subtraction
	function automatic logic [CPU_FIELD_W-1:0] cpu_wrap(input logic [CPU_FIELD_W-1:0] v,
		input int unsigned cnt);
		logic [CPU_FIELD_W-1:0] r;
		r = v;
		for (int i = 0; i < 8; i++) begin
			if (int'(r) >= int'(cnt)) begin
				r = r - CPU_FIELD_W'(cnt);
			end
		end
		return r;
	endfunction

endpackage

### hdl/pcpfl_sub_unit.sv
module pcpfl_sub_unit (
	input  logic [pcpfl_pkg::ADDR_W:0] a,
	input  logic [pcpfl_pkg::ADDR_W:0] b,
	output logic [pcpfl_pkg::ADDR_W:0] diff,
	output logic                       lt
);
	import pcpfl_pkg::*;

	logic [ADDR_W+1:0] full;

	// Shared subtract and compare: borrow out flags a below b
	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[ADDR_W:0];
	assign lt   = full[ADDR_W+1];

endmodule

### hdl/pcpfl_store.sv
module pcpfl_store #(
	parameter  int unsigned CPU_COUNT = pcpfl_pkg::CPU_COUNT_DEF,
	parameter  int unsigned NUM_PAGES = pcpfl_pkg::NUM_PAGES_DEF,
	localparam int unsigned CPU_W     = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
	localparam int unsigned PG_W      = $clog2(NUM_PAGES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcpfl_pkg::st_ctl_t   ctl,
	input  logic [CPU_W-1:0]     head_addr,
	input  logic [PG_W-1:0]      head_wpage,
	output logic [PG_W-1:0]      head_rpage,
	output logic [CPU_COUNT-1:0] head_valid,
	input  logic [PG_W-1:0]      link_waddr,
	input  logic [PG_W:0]        link_wdata,
	input  logic [PG_W-1:0]      link_raddr,
	output logic [PG_W:0]        link_rdata
);
	import pcpfl_pkg::*;

	logic [PG_W-1:0]      head_mem [CPU_COUNT];
	logic [PG_W:0]        link_mem [NUM_PAGES];
	logic [CPU_COUNT-1:0] hv_q;
	logic [PG_W-1:0]      head_rpage_q;
	logic [PG_W:0]        link_rdata_q;

	// Head page numbers: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.head_we) begin
			head_mem[head_addr] <= head_wpage;
		end
		head_rpage_q <= head_mem[head_addr];
	end

	// Next links: valid bit over page number, contents undefined until pushed
	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rdata_q <= link_mem[link_raddr];
	end

	// Head valid bits: all lists empty after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= '0;
		end else if (ctl.head_we) begin
			hv_q[head_addr] <= ctl.head_valid;
		end
	end

	assign head_rpage = head_rpage_q;
	assign head_valid = hv_q;
	assign link_rdata = link_rdata_q;

endmodule

### hdl/per_cpu_page_free_list_with_steal.sv
// Free checks alignment and the region bounds, the offset from the table base and the page
// index, then pushes; allocate checks the own list, else scans the lists to steal
// a page, then reads the head page and its link and pops. One item at a time: new input is
// taken only in idle, after the result is loaded into the output register.
// Reset (arst_n, asynchronous): all lists empty, registers at their reset values, no result.
module per_cpu_page_free_list_with_steal #(
	parameter int unsigned CPU_COUNT  = pcpfl_pkg::CPU_COUNT_DEF,
	parameter int unsigned NUM_PAGES  = pcpfl_pkg::NUM_PAGES_DEF,
	parameter int unsigned PAGE_BYTES = pcpfl_pkg::PAGE_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [pcpfl_pkg::CPU_FIELD_W-1:0]   cpu_number,
	input  logic [pcpfl_pkg::ADDR_W-1:0]        page_address,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pcpfl_pkg::ADDR_W-1:0]        granted_address,
	output logic [pcpfl_pkg::STATUS_W-1:0]      status,
	output logic                                stolen,
	input  logic                                cfg_we,
	input  logic [pcpfl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcpfl_pkg::ADDR_W-1:0]        cfg_wdata
);
	import pcpfl_pkg::*;

	localparam int unsigned CPU_W      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int unsigned PG_W       = $clog2(NUM_PAGES);
	localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W+1)'(PAGE_BYTES - 1);
	localparam logic [ADDR_W:0] BASE_RST  = (ADDR_W+1)'(
		((64'(REGION_START_RST) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES))
		* 64'(PAGE_BYTES));

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_F_LO   = 12'b0000_0000_0010,
		S_F_HI   = 12'b0000_0000_0100,
		S_F_BASE = 12'b0000_0000_1000,
		S_F_IDX  = 12'b0000_0001_0000,
		S_F_PUSH = 12'b0000_0010_0000,
		S_A_CHK  = 12'b0000_0100_0000,
		S_A_SCAN = 12'b0000_1000_0000,
		S_A_READ = 12'b0001_0000_0000,
		S_A_LINK = 12'b0010_0000_0000,
		S_A_POP  = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	state_t                state_q;
	logic [CPU_W-1:0]      cpu_q;
	logic [CPU_W-1:0]      src_q;
	logic [CPU_W-1:0]      scan_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [ADDR_W:0]       diff_q;
	logic [PG_W-1:0]       page_q;
	logic [ADDR_W-1:0]     start_q;
	logic [ADDR_W-1:0]     end_q;
	logic [ADDR_W:0]       base_q;
	logic [ADDR_W-1:0]     res_addr_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  res_stolen_q;
	logic                  out_valid_q;
	logic [ADDR_W-1:0]     out_addr_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_stolen_q;

	logic [CPU_FIELD_W-1:0] cpu_mod;
	logic [CPU_W+2:0]       cpu_ext;
	logic [CPU_W-1:0]       cpu_in;
	logic [ADDR_W:0]        sub_a;
	logic [ADDR_W:0]        sub_b;
	logic [ADDR_W:0]        sub_diff;
	logic                   sub_lt;
	logic                   aligned;
	logic [63:0]            idx_full;
	logic [PG_W-1:0]        idx;
	logic                   idx_ok;
	logic [ADDR_W+2:0]      grant_sum;
	logic                   out_free;

	st_ctl_t                st_ctl;
	logic [PG_W-1:0]        head_wpage;
	logic [PG_W-1:0]        head_rpage;
	logic [CPU_COUNT-1:0]   head_valid;
	logic [PG_W:0]          link_wdata;
	logic [PG_W:0]          link_rdata;

	// Fold the requesting CPU onto the configured count
	assign cpu_mod = cpu_wrap(cpu_number, CPU_COUNT);
	assign cpu_ext = (CPU_W+3)'(cpu_mod);
	assign cpu_in  = cpu_ext[CPU_W-1:0];

	// Operand selection for the shared subtractor
	always_comb begin
		sub_a = {1'b0, addr_q};
		case (state_q)
			S_F_HI:   sub_b = {1'b0, end_q};
			S_F_BASE: sub_b = base_q;
			default:  sub_b = {1'b0, start_q};
		endcase
	end

	pcpfl_sub_unit u_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff),
		.lt   (sub_lt)
	);

	// Page index and the granted address
	assign aligned   = (sub_a & PAGE_MASK) == '0;
	assign idx_full  = 64'(diff_q >> PAGE_SHIFT);
	assign idx       = idx_full[PG_W-1:0];
	assign idx_ok    = idx_full < 64'(NUM_PAGES);
	assign grant_sum = (ADDR_W+3)'(base_q) + ((ADDR_W+3)'(page_q) << PAGE_SHIFT);

	// Store writes: push on free, pop on allocate
	always_comb begin
		st_ctl.head_we    = (state_q == S_F_PUSH) || (state_q == S_A_POP);
		st_ctl.head_valid = (state_q == S_F_PUSH) ? 1'b1 : link_rdata[PG_W];
		st_ctl.link_we    = (state_q == S_F_PUSH);
		head_wpage        = (state_q == S_F_PUSH) ? idx : link_rdata[PG_W-1:0];
		link_wdata        = {head_valid[src_q], head_rpage};
	end

	pcpfl_store #(
		.CPU_COUNT (CPU_COUNT),
		.NUM_PAGES (NUM_PAGES)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (st_ctl),
		.head_addr  (src_q),
		.head_wpage (head_wpage),
		.head_rpage (head_rpage),
		.head_valid (head_valid),
		.link_waddr (idx),
		.link_wdata (link_wdata),
		.link_raddr (head_rpage),
		.link_rdata (link_rdata)
	);

	// Configuration registers; the table base follows region_start rounded up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= REGION_START_RST;
			end_q   <= REGION_END_RST;
			base_q  <= BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REGION_START: begin
					start_q <= cfg_wdata;
					base_q  <= ((ADDR_W+1)'(cfg_wdata) + PAGE_MASK) & ~PAGE_MASK;
				end
				CFG_REGION_END: begin
					end_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cpu_q        <= '0;
			src_q        <= '0;
			scan_q       <= '0;
			addr_q       <= '0;
			diff_q       <= '0;
			page_q       <= '0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			res_stolen_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_status_q <= ST_OK;
			out_stolen_q <= 1'b0;
		end else begin
			// Drop the result once transferred
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cpu_q        <= cpu_in;
						src_q        <= cpu_in;
						addr_q       <= page_address;
						res_addr_q   <= '0;
						res_status_q <= ST_OK;
						res_stolen_q <= 1'b0;
						state_q      <= (operation == OP_FREE) ? S_F_LO : S_A_CHK;
					end
				end
				// Free: check alignment and the lower bound
				S_F_LO: begin
					if (!aligned || sub_lt) begin
						res_status_q <= ST_BAD_FREE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_F_HI;
					end
				end
				// Free: check the upper bound
				S_F_HI: begin
					if (!sub_lt) begin
						res_status_q <= ST_BAD_FREE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_F_BASE;
					end
				end
				// Free: offset from the table base
				S_F_BASE: begin
					diff_q <= sub_diff;
					if (sub_lt) begin
						res_status_q <= ST_BAD_FREE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_F_IDX;
					end
				end
				// Free: page index within the table
				S_F_IDX: begin
					if (!idx_ok) begin
						res_status_q <= ST_BAD_FREE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_F_PUSH;
					end
				end
				// Free: link the old head behind the page and make it the head
				S_F_PUSH: begin
					state_q <= S_DONE;
				end
				// Allocate: own list first
				S_A_CHK: begin
					if (head_valid[cpu_q]) begin
						state_q <= S_A_READ;
					end else begin
						scan_q  <= '0;
						state_q <= S_A_SCAN;
					end
				end
				// Allocate: scan the lists in ascending order from CPU 0, one per cycle
				S_A_SCAN: begin
					if (head_valid[scan_q]) begin
						src_q        <= scan_q;
						res_stolen_q <= 1'b1;
						state_q      <= S_A_READ;
					end else if (scan_q == CPU_W'(CPU_COUNT - 1)) begin
						res_status_q <= ST_OOM;
						state_q      <= S_DONE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				// Allocate: head page read in flight
				S_A_READ: begin
					state_q <= S_A_LINK;
				end
				// Allocate: hold the head page, link read in flight
				S_A_LINK: begin
					page_q  <= head_rpage;
					state_q <= S_A_POP;
				end
				// Allocate: advance the head to the next link
				S_A_POP: begin
					res_addr_q <= grant_sum[ADDR_W-1:0];
					state_q    <= S_DONE;
				end
				// Load the result once the output register is free
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						out_stolen_q <= res_stolen_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign granted_address = out_addr_q;
	assign status          = out_status_q;
	assign stolen          = out_stolen_q;

endmodule
